>>> sv/ftstat_pkg.sv
// ----------------------------------------------------------------------------
// Frame time statistics package
// Shared widths, reset values, codes and the controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ftstat_pkg;

  // Window length in frames (2 .. 127).
  localparam int WINDOW_FRAMES = 60;

  // Field and register widths.
  localparam int KIND_W    = 2;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int Q8_W      = 24;
  localparam int FRAMES_W  = 7;
  localparam int SUM_W     = 32;
  localparam int WAIT_W    = 16;

  // Wait computation widths: frames * target, and the signed Q8 difference.
  localparam int PROD_W = FRAMES_W + CFG_W;
  localparam int DIFF_W = TIME_W + 9;

  // Sequential divider for the rate.
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Average by reciprocal multiplication: floor(sum / WINDOW_FRAMES) equals
  // (sum * AVG_MAGIC) >> AVG_SHIFT for every 32-bit sum.
  localparam int AVG_SHIFT   = SUM_W + $clog2(WINDOW_FRAMES);
  localparam int AVG_MAGIC_W = SUM_W + 1;
  localparam int AVG_PROD_W  = SUM_W + AVG_MAGIC_W;
  localparam logic [AVG_MAGIC_W-1:0] AVG_MAGIC = AVG_MAGIC_W'(
    ((64'd1 << AVG_SHIFT) + 64'(WINDOW_FRAMES) - 64'd1) / 64'(WINDOW_FRAMES));

  // Reset values.
  localparam logic [CFG_W-1:0] TARGET_RESET  = 16'd4267;
  localparam logic [CFG_W-1:0] LIMIT_RESET   = 16'd500;
  localparam logic [Q8_W-1:0]  RATE_RESET_Q8 = 24'd15360;
  localparam logic [Q8_W-1:0]  Q8_MAX        = 24'hFF_FFFF;

  // Window length as a count, and the rate numerator 1000 ms * 256 * frames.
  localparam logic [FRAMES_W-1:0] WINDOW_COUNT = FRAMES_W'(WINDOW_FRAMES);
  localparam logic [DIV_W-1:0]    RATE_NUM     = DIV_W'(256000 * WINDOW_FRAMES);
  localparam logic [DIV_W-1:0]    WINDOW_DIV   = DIV_W'(WINDOW_FRAMES);

  // Item kinds; the remaining code is an item that changes nothing.
  typedef enum logic [KIND_W-1:0] {
    KIND_START = 2'd0,
    KIND_FRAME = 2'd1,
    KIND_WAIT  = 2'd2
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET = 1'b0,
    CFG_LIMIT  = 1'b1
  } cfg_idx_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RATE,
    ST_DIV,
    ST_WAIT,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     start;
    logic     frame;
    logic     div_start;
    logic     commit_rate;
    logic     commit_avg;
    logic     wait_mul;
    logic     wait_sub;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              window_full;
    logic              div_done;
    logic              out_busy;
  } status_t;

  // One result item.
  typedef struct packed {
    logic [Q8_W-1:0]   frame_ms_q8;
    logic              frame_ok;
    logic              window_done;
    logic [Q8_W-1:0]   rate_q8;
    logic [Q8_W-1:0]   avg_q8;
    logic [Q8_W-1:0]   min_q8;
    logic [Q8_W-1:0]   max_q8;
    logic [WAIT_W-1:0] wait_ms;
  } result_t;

endpackage

`default_nettype wire

>>> sv/ftstat_if.sv
// ----------------------------------------------------------------------------
// Frame time statistics channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

// Input item channel.
interface ftstat_in_if;
  import ftstat_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, kind, now_ms, input ready);
  modport sink   (input valid, kind, now_ms, output ready);
endinterface

// Result item channel.
interface ftstat_out_if;
  import ftstat_pkg::*;

  logic              valid;
  logic              ready;
  logic [Q8_W-1:0]   frame_ms_q8;
  logic              frame_ok;
  logic              window_done;
  logic [Q8_W-1:0]   rate_q8;
  logic [Q8_W-1:0]   avg_q8;
  logic [Q8_W-1:0]   min_q8;
  logic [Q8_W-1:0]   max_q8;
  logic [WAIT_W-1:0] wait_ms;

  modport source (output valid, frame_ms_q8, frame_ok, window_done, rate_q8, avg_q8,
                  min_q8, max_q8, wait_ms, input ready);
  modport sink   (input valid, frame_ms_q8, frame_ok, window_done, rate_q8, avg_q8,
                  min_q8, max_q8, wait_ms, output ready);
endinterface

`default_nettype wire

>>> sv/frame_time_statistics_core.sv
// ----------------------------------------------------------------------------
// Frame time statistics core
// Windowed frame rate monitor with pacing query.
// ----------------------------------------------------------------------------
// One item is handled at a time. A start, an ordinary frame update or an
// unused kind goes from the execute state straight to the output state, and a
// wait query first multiplies, then subtracts and saturates. The frame that
// closes a window runs the 32-step rate divider; its average comes from a
// reciprocal multiply that is ready alongside the rate.
// The input is ready again in the cycle after the result is loaded into the
// output register, even if that result has not yet been transferred out; a
// result that waits there holds the next one back in the controller.
`default_nettype none

module frame_time_statistics_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ftstat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ftstat_pkg::CFG_W-1:0]     cfg_data,
  ftstat_in_if.sink                        in_ch,
  ftstat_out_if.source                     out_ch
);
  import ftstat_pkg::*;

  cmd_t    cmd;
  status_t status;
  result_t result;
  logic    out_valid;

  ftstat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ftstat_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_kind   (in_ch.kind),
    .in_now    (in_ch.now_ms),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .result    (result)
  );

  // Result channel.
  assign out_ch.valid       = out_valid;
  assign out_ch.frame_ms_q8 = result.frame_ms_q8;
  assign out_ch.frame_ok    = result.frame_ok;
  assign out_ch.window_done = result.window_done;
  assign out_ch.rate_q8     = result.rate_q8;
  assign out_ch.avg_q8      = result.avg_q8;
  assign out_ch.min_q8      = result.min_q8;
  assign out_ch.max_q8      = result.max_q8;
  assign out_ch.wait_ms     = result.wait_ms;

endmodule

`default_nettype wire

>>> sv/ftstat_div.sv
// ----------------------------------------------------------------------------
// Frame time statistics divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ftstat_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ftstat_pkg::DIV_W-1:0] dividend,
  input  logic [ftstat_pkg::DIV_W-1:0] divisor,
  output logic                         done,
  output logic [ftstat_pkg::DIV_W-1:0] quotient
);
  import ftstat_pkg::*;

  logic [DIV_W:0]     rem;
  logic [DIV_W-1:0]   quo;
  logic [DIV_W-1:0]   dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic               busy;
  logic [DIV_W:0]     rem_sh;
  logic [DIV_W:0]     rem_sub;
  logic               fits;

  // Shift in the next dividend bit and trial-subtract the divisor.
  always_comb begin
    rem_sh  = {rem[DIV_W-1:0], quo[DIV_W-1]};
    fits    = (rem_sh >= {1'b0, dvs});
    rem_sub = rem_sh - {1'b0, dvs};
  end

  // Control: busy for DIV_W steps, done pulses after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operands and partial remainder; the dividend shifts out as quotient bits enter.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? rem_sub : rem_sh;
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

>>> sv/ftstat_dp.sv
// ----------------------------------------------------------------------------
// Frame time statistics datapath
// Configuration, window statistics, published values, pacing and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ftstat_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ftstat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ftstat_pkg::CFG_W-1:0]     cfg_data,
  input  logic [ftstat_pkg::KIND_W-1:0]    in_kind,
  input  logic [ftstat_pkg::TIME_W-1:0]    in_now,
  input  ftstat_pkg::cmd_t                 cmd,
  output ftstat_pkg::status_t              status,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ftstat_pkg::result_t              result
);
  import ftstat_pkg::*;

  // Configuration registers.
  logic [CFG_W-1:0] target;
  logic [CFG_W-1:0] limit;

  // Current item.
  logic [KIND_W-1:0] item_kind;
  logic [TIME_W-1:0] item_now;

  // Window and published state.
  logic [TIME_W-1:0]   last_time;
  logic [TIME_W-1:0]   win_start;
  logic [FRAMES_W-1:0] frames;
  logic [SUM_W-1:0]    sum;
  logic [Q8_W-1:0]     win_min;
  logic [Q8_W-1:0]     win_max;
  logic [Q8_W-1:0]     pub_rate;
  logic [Q8_W-1:0]     pub_avg;
  logic [Q8_W-1:0]     pub_min;
  logic [Q8_W-1:0]     pub_max;

  // Values held for the rate and average after a window closes.
  logic [SUM_W-1:0]  sum_hold;
  logic [TIME_W-1:0] span_hold;
  logic              span_bad;

  // Per-item result fields.
  logic [Q8_W-1:0]   res_frame;
  logic              res_ok;
  logic              res_done;
  logic [WAIT_W-1:0] res_wait;

  // Pacing pipeline.
  logic [PROD_W-1:0] prod_q;
  logic [TIME_W-1:0] act_q;

  // Combinational frame terms.
  logic [TIME_W-1:0]   elapsed;
  logic                elapsed_ok;
  logic [Q8_W-1:0]     frame_q8;
  logic [TIME_W-1:0]   span;
  logic                full;
  logic                first;
  logic                div_done;
  logic [DIV_W-1:0]    div_quotient;
  logic [AVG_PROD_W-1:0] avg_prod;
  logic signed [DIFF_W-1:0] diff;
  logic [TIME_W-1:0]   wait_whole;
  logic [WAIT_W-1:0]   wait_sat;

  // Frame time: measured if in range, otherwise the target.
  always_comb begin
    elapsed    = item_now - last_time;
    elapsed_ok = (elapsed != '0) && (elapsed < {{(TIME_W-CFG_W){1'b0}}, limit});
    frame_q8   = elapsed_ok ? {elapsed[CFG_W-1:0], 8'd0}
                            : {{(Q8_W-CFG_W){1'b0}}, target};
    span       = item_now - win_start;
    full       = (frames == WINDOW_COUNT);
    first      = full || (frames == '0);
  end

  // Rate: numerator 1000 ms * 256 * frames over the window span.
  ftstat_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (RATE_NUM),
    .divisor  (span_hold),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Average: window sum times the reciprocal of the frame count.
  always_comb begin
    avg_prod = {{AVG_MAGIC_W{1'b0}}, sum_hold} * {{SUM_W{1'b0}}, AVG_MAGIC};
  end

  // Pacing: Q8 deadline minus Q8 elapsed time, truncated to whole ms, saturated.
  always_comb begin
    diff = $signed({{(DIFF_W-PROD_W){1'b0}}, prod_q})
         - $signed({act_q[TIME_W-1], act_q, 8'd0});
    wait_whole = diff[TIME_W+7:8];
    if (diff[DIFF_W-1] || (diff == '0)) begin
      wait_sat = '0;
    end else if (wait_whole[TIME_W-1:WAIT_W] != '0) begin
      wait_sat = '1;
    end else begin
      wait_sat = wait_whole[WAIT_W-1:0];
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      target    <= TARGET_RESET;
      limit     <= LIMIT_RESET;
      last_time <= '0;
      win_start <= '0;
      frames    <= '0;
      sum       <= '0;
      win_min   <= {{(Q8_W-CFG_W){1'b0}}, TARGET_RESET};
      win_max   <= {{(Q8_W-CFG_W){1'b0}}, TARGET_RESET};
      pub_rate  <= RATE_RESET_Q8;
      pub_avg   <= {{(Q8_W-CFG_W){1'b0}}, TARGET_RESET};
      pub_min   <= {{(Q8_W-CFG_W){1'b0}}, TARGET_RESET};
      pub_max   <= {{(Q8_W-CFG_W){1'b0}}, TARGET_RESET};
    end else begin
      // Configuration writes.
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_TARGET: target <= cfg_data;
          CFG_LIMIT:  limit  <= cfg_data;
          default:    ;
        endcase
      end

      // Start: restart the window and republish the defaults.
      if (cmd.start) begin
        win_start <= item_now;
        last_time <= item_now;
        frames    <= '0;
        sum       <= '0;
        win_min   <= {{(Q8_W-CFG_W){1'b0}}, target};
        win_max   <= {{(Q8_W-CFG_W){1'b0}}, target};
        pub_rate  <= RATE_RESET_Q8;
        pub_avg   <= {{(Q8_W-CFG_W){1'b0}}, target};
        pub_min   <= {{(Q8_W-CFG_W){1'b0}}, target};
        pub_max   <= {{(Q8_W-CFG_W){1'b0}}, target};
      end

      // Frame: close a full window, then accumulate this frame.
      if (cmd.frame) begin
        last_time <= item_now;
        if (full) begin
          pub_min <= win_min;
          pub_max <= win_max;
        end
        if (first) begin
          win_start <= item_now;
          win_min   <= frame_q8;
          win_max   <= frame_q8;
          sum       <= {{(SUM_W-Q8_W){1'b0}}, frame_q8};
          frames    <= FRAMES_W'(1);
        end else begin
          if (frame_q8 < win_min) begin
            win_min <= frame_q8;
          end
          if (frame_q8 > win_max) begin
            win_max <= frame_q8;
          end
          sum    <= sum + {{(SUM_W-Q8_W){1'b0}}, frame_q8};
          frames <= frames + 1'b1;
        end
      end

      // Rate and average of the closed window.
      if (cmd.commit_rate) begin
        if (span_bad || div_quotient[DIV_W-1:Q8_W] != '0) begin
          pub_rate <= Q8_MAX;
        end else begin
          pub_rate <= div_quotient[Q8_W-1:0];
        end
      end
      if (cmd.commit_avg) begin
        pub_avg <= avg_prod[AVG_SHIFT +: Q8_W];
      end
    end
  end

  // Item, per-item results and operand holding registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_kind <= in_kind;
      item_now  <= in_now;
      res_frame <= '0;
      res_ok    <= 1'b0;
      res_done  <= 1'b0;
      res_wait  <= '0;
    end
    if (cmd.frame) begin
      res_frame <= frame_q8;
      res_ok    <= elapsed_ok;
      res_done  <= full;
      sum_hold  <= sum;
      span_hold <= span;
      span_bad  <= (span == '0) || span[TIME_W-1];
    end
    if (cmd.wait_mul) begin
      prod_q <= frames * target;
      act_q  <= span;
    end
    if (cmd.wait_sub) begin
      res_wait <= wait_sat;
    end
  end

  // Output register: holds a result until the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.frame_ms_q8 <= res_frame;
      result.frame_ok    <= res_ok;
      result.window_done <= res_done;
      result.rate_q8     <= pub_rate;
      result.avg_q8      <= pub_avg;
      result.min_q8      <= pub_min;
      result.max_q8      <= pub_max;
      result.wait_ms     <= res_wait;
    end
  end

  // Status to the controller.
  always_comb begin
    status.kind        = item_kind;
    status.window_full = full;
    status.div_done    = div_done;
    status.out_busy    = out_valid && !out_ready;
  end

endmodule

`default_nettype wire

>>> sv/ftstat_ctrl.sv
// ----------------------------------------------------------------------------
// Frame time statistics controller
// Sequences one item through update, rate division, pacing and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ftstat_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ftstat_pkg::status_t status,
  output ftstat_pkg::cmd_t    cmd
);
  import ftstat_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (kind_t'(status.kind))
          KIND_START: begin
            cmd.start  = 1'b1;
            state_next = ST_OUT;
          end
          KIND_FRAME: begin
            cmd.frame = 1'b1;
            if (status.window_full) begin
              state_next = ST_RATE;
            end else begin
              state_next = ST_OUT;
            end
          end
          KIND_WAIT: begin
            cmd.wait_mul = 1'b1;
            state_next   = ST_WAIT;
          end
          default: begin
            state_next = ST_OUT;
          end
        endcase
      end
      ST_RATE: begin
        // The span and sum were captured by the frame update; start the rate.
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        // The average needs no wait, so both land when the rate is done.
        if (status.div_done) begin
          cmd.commit_rate = 1'b1;
          cmd.commit_avg  = 1'b1;
          state_next      = ST_OUT;
        end
      end
      ST_WAIT: begin
        cmd.wait_sub = 1'b1;
        state_next   = ST_OUT;
      end
      ST_OUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/ftstat_checker.sv
// ----------------------------------------------------------------------------
// Frame time statistics checker
// Port-level properties of the core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ftstat_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] frame_ms_q8,
  input logic        frame_ok,
  input logic        window_done,
  input logic [15:0] wait_ms
);

  // A result stays offered until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // Items are handled one at a time: no transfer in right after another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // A measured frame time is a whole, nonzero number of milliseconds.
  a_measured_whole: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_ok |-> (frame_ms_q8[7:0] == 8'd0) && (frame_ms_q8 != 24'd0))
    else $error("measured frame time not whole ms");

  // A pacing answer never comes with frame fields.
  a_wait_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && (wait_ms != 16'd0) |-> !frame_ok && !window_done && (frame_ms_q8 == 24'd0))
    else $error("pacing answer mixed with frame result");

endmodule

bind frame_time_statistics_core ftstat_checker u_ftstat_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .frame_ms_q8 (out_ch.frame_ms_q8),
  .frame_ok    (out_ch.frame_ok),
  .window_done (out_ch.window_done),
  .wait_ms     (out_ch.wait_ms)
);

`default_nettype wire

>>> verif/frame_time_statistics_core_tb.sv
// ----------------------------------------------------------------------------
// Frame time statistics core testbench
// Sends start, frame, wait and unused items under random idling on both sides.
// A local model of the window statistics predicts every result item, and each
// transfer out is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module frame_time_statistics_core_tb;
  import ftstat_pkg::*;

  // The one kind code that the block ignores.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int DRAIN_CYCLES    = 100;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_CYCLES = 2000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  ftstat_in_if  in_ch ();
  ftstat_out_if out_ch ();

  frame_time_statistics_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Local copy of the configuration and the window statistics.
  logic [CFG_W-1:0]    target_reg;
  logic [CFG_W-1:0]    limit_reg;
  logic [TIME_W-1:0]   last_t;
  logic [TIME_W-1:0]   win_start;
  logic [FRAMES_W-1:0] frame_cnt;
  logic [SUM_W-1:0]    sum_q8;
  logic [Q8_W-1:0]     win_min;
  logic [Q8_W-1:0]     win_max;
  logic [Q8_W-1:0]     pub_rate;
  logic [Q8_W-1:0]     pub_avg;
  logic [Q8_W-1:0]     pub_min;
  logic [Q8_W-1:0]     pub_max;

  // Predicted reports, oldest first.
  result_t stat_reports[$];

  result_t           got;
  result_t           want;
  logic [TIME_W-1:0] clock_ms;
  bit                idle_en;
  bit                hold_req;
  int                error_count  = 0;
  int                result_count = 0;
  int                stall_cycles = 0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Window restart, shared by reset and by start items.
  task automatic restart_window(input logic [TIME_W-1:0] t);
    win_start = t;
    last_t    = t;
    frame_cnt = '0;
    sum_q8    = '0;
    win_min   = {8'd0, target_reg};
    win_max   = {8'd0, target_reg};
    pub_rate  = RATE_RESET_Q8;
    pub_avg   = {8'd0, target_reg};
    pub_min   = {8'd0, target_reg};
    pub_max   = {8'd0, target_reg};
  endtask

  // Advance the statistics by one accepted item and queue its report.
  task automatic update_frame_stats(input logic [KIND_W-1:0] k, input logic [TIME_W-1:0] t);
    result_t            r;
    logic [TIME_W-1:0]  elapsed;
    logic [TIME_W-1:0]  span;
    logic [TIME_W-1:0]  delta;
    logic [DIV_W-1:0]   quot;
    logic [Q8_W-1:0]    frame_q8;
    logic signed [63:0] actual;
    logic signed [63:0] prod;
    logic signed [63:0] diff;
    logic signed [63:0] whole_ms;
    r = '0;
    case (k)
      KIND_START: begin
        restart_window(t);
      end
      KIND_FRAME: begin
        elapsed = t - last_t;
        if (elapsed >= 32'd1 && elapsed < {16'd0, limit_reg}) begin
          frame_q8   = {elapsed[15:0], 8'd0};
          r.frame_ok = 1'b1;
        end else begin
          frame_q8 = {8'd0, target_reg};
        end
        last_t = t;
        // A full window is published by the frame that follows it.
        if (frame_cnt == WINDOW_COUNT) begin
          span = t - win_start;
          if (span == '0 || span[TIME_W-1]) begin
            pub_rate = Q8_MAX;
          end else begin
            quot     = RATE_NUM / span;
            pub_rate = (quot > {8'd0, Q8_MAX}) ? Q8_MAX : quot[Q8_W-1:0];
          end
          quot          = sum_q8 / WINDOW_DIV;
          pub_avg       = quot[Q8_W-1:0];
          pub_min       = win_min;
          pub_max       = win_max;
          frame_cnt     = '0;
          win_start     = t;
          sum_q8        = '0;
          r.window_done = 1'b1;
        end
        if (frame_cnt == '0) begin
          win_start = t;
          win_min   = frame_q8;
          win_max   = frame_q8;
        end else begin
          if (frame_q8 < win_min) win_min = frame_q8;
          if (frame_q8 > win_max) win_max = frame_q8;
        end
        sum_q8        = sum_q8 + {8'd0, frame_q8};
        frame_cnt     = frame_cnt + 1'b1;
        r.frame_ms_q8 = frame_q8;
      end
      KIND_WAIT: begin
        delta  = t - win_start;
        actual = {{32{delta[TIME_W-1]}}, delta};
        prod   = {57'd0, frame_cnt} * {48'd0, target_reg};
        diff   = prod - actual * 64'sd256;
        if (diff > 64'sd0) begin
          whole_ms  = diff >>> 8;
          r.wait_ms = (whole_ms > 64'sd65535) ? 16'hFFFF : whole_ms[WAIT_W-1:0];
        end
      end
      default: begin
      end
    endcase
    r.rate_q8 = pub_rate;
    r.avg_q8  = pub_avg;
    r.min_q8  = pub_min;
    r.max_q8  = pub_max;
    stat_reports.push_back(r);
  endtask

  // Mismatch reporting.
  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
             result_count, what, seen, wanted);
    error_count++;
  endtask

  // Configuration write, applied to the local copy at the same edge.
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == CFG_TARGET) target_reg = val;
    else limit_reg = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One input transfer, with an optional idle burst in front of it.
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [TIME_W-1:0] t);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.kind   <= k;
    in_ch.now_ms <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    update_frame_stats(k, t);
  endtask

  // Frame item a given number of ms after the previous timestamp.
  task automatic send_frame(input logic [TIME_W-1:0] delta);
    clock_ms = clock_ms + delta;
    send_item(KIND_FRAME, clock_ms);
  endtask

  // Wait until every report has arrived and the block has settled.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (stat_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Frame spacing: mostly plausible, sometimes zero, near the limit,
  // wild or backwards.
  function automatic logic [TIME_W-1:0] pick_delta();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return $urandom_range(1, 40);
    if (sel < 85) return 32'd0;
    if (sel < 90) return {16'd0, limit_reg} + $urandom_range(0, 2) - 32'd1;
    if (sel < 95) return $urandom();
    return 32'd0 - $urandom_range(1, 100);
  endfunction

  task automatic send_random_item();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 2) begin
      if ($urandom_range(0, 1) == 0) clock_ms = $urandom();
      send_item(KIND_START, clock_ms);
    end else if (sel < 4) begin
      send_item(KIND_UNUSED, $urandom());
    end else if (sel < 6) begin
      send_item(KIND_WAIT, $urandom());
    end else if (sel < 14) begin
      send_item(KIND_WAIT, clock_ms + $urandom_range(0, 60));
    end else begin
      send_frame(pick_delta());
    end
  endtask

  // Items right after reset, against the reset configuration.
  task automatic test_after_reset();
    send_item(KIND_UNUSED, 32'h1234_5678);
    send_item(KIND_WAIT, 32'd0);
    send_item(KIND_FRAME, 32'd0);
    send_item(KIND_FRAME, 32'd17);
    send_item(KIND_WAIT, 32'd20);
  endtask

  // Field extremes, wrap of the timestamp, limit edges and wait saturation.
  task automatic test_edge_values();
    clock_ms = 32'hFFFF_FFF0;
    send_item(KIND_START, clock_ms);
    send_item(KIND_WAIT, clock_ms + 32'h8000_0000);
    send_item(KIND_WAIT, clock_ms + 32'd1000);
    send_frame(32'd21);
    send_frame({16'd0, limit_reg} - 32'd1);
    send_frame({16'd0, limit_reg});
    send_frame(32'd0);
    send_frame(32'hFFFF_FFF6);
    send_frame(32'd1);
    send_item(KIND_WAIT, clock_ms);
    send_item(KIND_UNUSED, 32'hFFFF_FFFF);
    clock_ms = 32'hFFFF_FFFF;
    send_item(KIND_FRAME, clock_ms);
    send_frame(32'd1);
    send_item(KIND_START, clock_ms);
    wait_idle();
    // Largest registers: the start picks up the new target frame time.
    write_reg(CFG_TARGET, 16'hFFFF);
    write_reg(CFG_LIMIT, 16'hFFFF);
    send_item(KIND_START, clock_ms);
    send_frame(32'd65534);
    send_frame(32'd65535);
    send_item(KIND_WAIT, clock_ms);
    wait_idle();
    // Smallest registers.
    write_reg(CFG_TARGET, 16'd256);
    write_reg(CFG_LIMIT, 16'd2);
    send_item(KIND_START, clock_ms);
    send_frame(32'd1);
    send_frame(32'd2);
    send_item(KIND_WAIT, clock_ms);
  endtask

  // Complete windows with random frame spacing and interleaved wait queries.
  task automatic test_full_windows();
    for (int cfg = 0; cfg < 2; cfg++) begin
      wait_idle();
      if (cfg == 0) begin
        write_reg(CFG_TARGET, TARGET_RESET);
        write_reg(CFG_LIMIT, LIMIT_RESET);
      end else begin
        write_reg(CFG_TARGET, 16'($urandom_range(256, 8000)));
        write_reg(CFG_LIMIT, 16'($urandom_range(20, 600)));
      end
      clock_ms = $urandom();
      send_item(KIND_START, clock_ms);
      repeat (WINDOW_FRAMES + 10) begin
        if ($urandom_range(0, 7) == 0) send_item(KIND_WAIT, clock_ms + $urandom_range(0, 30));
        send_frame(pick_delta());
      end
    end
  endtask

  // Windows that close with a zero, a one ms and a negative span.
  task automatic test_span_limits();
    wait_idle();
    write_reg(CFG_TARGET, TARGET_RESET);
    write_reg(CFG_LIMIT, LIMIT_RESET);
    clock_ms = $urandom();
    send_item(KIND_START, clock_ms);
    repeat (WINDOW_FRAMES + 1) send_frame(32'd0);
    repeat (WINDOW_FRAMES - 1) send_frame(32'd0);
    send_frame(32'd1);
    repeat (WINDOW_FRAMES - 1) send_frame(32'd3);
    // Closing frame 1000 ms back.
    send_frame(32'hFFFF_FC18);
    send_item(KIND_WAIT, clock_ms);
  endtask

  // Limits of 0 and 1 ms force the fallback for every frame.
  task automatic test_tiny_limit();
    for (int lim = 0; lim < 2; lim++) begin
      wait_idle();
      write_reg(CFG_LIMIT, 16'(lim));
      send_item(KIND_START, clock_ms);
      repeat (5) send_frame($urandom_range(0, 3));
      send_item(KIND_WAIT, clock_ms);
    end
  endtask

  // Receiver holds off for a long stretch while items keep coming, then the
  // sender pauses until everything has drained.
  task automatic test_output_stall();
    wait_idle();
    write_reg(CFG_TARGET, TARGET_RESET);
    write_reg(CFG_LIMIT, LIMIT_RESET);
    hold_req = 1'b1;
    repeat (25) send_frame($urandom_range(1, 40));
    wait_idle();
  endtask

  // Random traffic in phases with fresh register settings; the last phase
  // runs without idling.
  task automatic test_random_mix();
    logic [CFG_W-1:0] tgt;
    logic [CFG_W-1:0] lim;
    for (int phase = 0; phase < 3; phase++) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0:       tgt = 16'd256;
        1:       tgt = 16'hFFFF;
        2:       tgt = TARGET_RESET;
        default: tgt = 16'($urandom_range(256, 65535));
      endcase
      case ($urandom_range(0, 3))
        0:       lim = 16'd2;
        1:       lim = 16'hFFFF;
        2:       lim = LIMIT_RESET;
        default: lim = 16'($urandom_range(2, 1000));
      endcase
      write_reg(CFG_TARGET, tgt);
      write_reg(CFG_LIMIT, lim);
      if (phase == 2) idle_en = 1'b0;
      repeat (100) send_random_item();
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clk);
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 5) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result checking against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      result_count++;
      got.frame_ms_q8 = out_ch.frame_ms_q8;
      got.frame_ok    = out_ch.frame_ok;
      got.window_done = out_ch.window_done;
      got.rate_q8     = out_ch.rate_q8;
      got.avg_q8      = out_ch.avg_q8;
      got.min_q8      = out_ch.min_q8;
      got.max_q8      = out_ch.max_q8;
      got.wait_ms     = out_ch.wait_ms;
      if (stat_reports.size() == 0) begin
        report_mismatch("unexpected transfer", 32'd0, 32'd0);
      end else begin
        want = stat_reports.pop_front();
        if (got.frame_ms_q8 !== want.frame_ms_q8)
          report_mismatch("frame_ms_q8", got.frame_ms_q8, want.frame_ms_q8);
        if (got.frame_ok !== want.frame_ok)
          report_mismatch("frame_ok", got.frame_ok, want.frame_ok);
        if (got.window_done !== want.window_done)
          report_mismatch("window_done", got.window_done, want.window_done);
        if (got.rate_q8 !== want.rate_q8)
          report_mismatch("rate_q8", got.rate_q8, want.rate_q8);
        if (got.avg_q8 !== want.avg_q8)
          report_mismatch("avg_q8", got.avg_q8, want.avg_q8);
        if (got.min_q8 !== want.min_q8)
          report_mismatch("min_q8", got.min_q8, want.min_q8);
        if (got.max_q8 !== want.max_q8)
          report_mismatch("max_q8", got.max_q8, want.max_q8);
        if (got.wait_ms !== want.wait_ms)
          report_mismatch("wait_ms", got.wait_ms, want.wait_ms);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_CYCLES) begin
      $display("Timeout: no transfer for %0d cycles", stall_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_TARGET;
    cfg_data     <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.kind   <= KIND_START;
    in_ch.now_ms <= '0;
    idle_en      = 1'b1;
    hold_req     = 1'b0;
    clock_ms     = '0;
    target_reg   = TARGET_RESET;
    limit_reg    = LIMIT_RESET;
    restart_window('0);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_edge_values();
    test_full_windows();
    test_span_limits();
    test_tiny_limit();
    test_output_stall();
    test_random_mix();
    wait_idle();

    if (error_count == 0 && stat_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
